### rtl/mef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mef_pkg;

  localparam int MOTOR_SLOTS = 7;
  localparam int COUNTS_PER_TURN = 8192;

  localparam int SLOT_W = 3;
  localparam int ID_W = 11;
  localparam int SETTLE_W = 8;
  localparam int FRAMES_W = 9;
  localparam int POS_W = 16;
  localparam int STEP_W = 17;
  localparam int WIDE_W = 18;
  localparam int CNT_W = 32;
  localparam int PAY_W = 48;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(MOTOR_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_YAW = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_PITCH = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_TRIGGER = 3'd6;

  localparam logic signed [WIDE_W-1:0] TURN_W = WIDE_W'(COUNTS_PER_TURN);
  localparam logic signed [WIDE_W-1:0] HALF_TURN_W = WIDE_W'(COUNTS_PER_TURN / 2);
  localparam logic [CNT_W-1:0] TURN_COUNTS = CNT_W'(COUNTS_PER_TURN);
  localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;

  localparam logic [2:0] REG_CHASSIS_BASE = 3'd0;
  localparam logic [2:0] REG_YAW_ID = 3'd1;
  localparam logic [2:0] REG_PITCH_ID = 3'd2;
  localparam logic [2:0] REG_TRIGGER_ID = 3'd3;
  localparam logic [2:0] REG_SETTLE = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]     chassis_base_id;
    logic [ID_W-1:0]     yaw_id;
    logic [ID_W-1:0]     pitch_id;
    logic [ID_W-1:0]     trigger_id;
    logic [SETTLE_W-1:0] settle_frames;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic [POS_W-1:0]        position;
    logic signed [15:0]      motor_speed;
    logic signed [15:0]      drive_current;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       motor_slot;
    logic                    calibrating;
    logic [POS_W-1:0]        position;
    logic signed [STEP_W-1:0] step_delta;
    logic signed [CNT_W-1:0] turn_count;
    logic signed [CNT_W-1:0] total_count;
    logic signed [15:0]      motor_speed;
    logic signed [15:0]      drive_current;
  } res_t;

endpackage

`default_nettype wire

### rtl/mef_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module mef_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mef_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mef_pkg::DATA_W-1:0]  pwdata,
  output logic      [mef_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output mef_pkg::cfg_t                    cfg
);

  logic [2:0] index;
  logic       wr;

  assign index = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chassis_base_id <= 11'd513;
      cfg.yaw_id <= 11'd517;
      cfg.pitch_id <= 11'd518;
      cfg.trigger_id <= 11'd519;
      cfg.settle_frames <= 8'd50;
    end else if (wr) begin
      case (index)
        mef_pkg::REG_CHASSIS_BASE: cfg.chassis_base_id <= pwdata[mef_pkg::ID_W-1:0];
        mef_pkg::REG_YAW_ID:       cfg.yaw_id <= pwdata[mef_pkg::ID_W-1:0];
        mef_pkg::REG_PITCH_ID:     cfg.pitch_id <= pwdata[mef_pkg::ID_W-1:0];
        mef_pkg::REG_TRIGGER_ID:   cfg.trigger_id <= pwdata[mef_pkg::ID_W-1:0];
        mef_pkg::REG_SETTLE:       cfg.settle_frames <= pwdata[mef_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      mef_pkg::REG_CHASSIS_BASE: prdata = 32'(cfg.chassis_base_id);
      mef_pkg::REG_YAW_ID:       prdata = 32'(cfg.yaw_id);
      mef_pkg::REG_PITCH_ID:     prdata = 32'(cfg.pitch_id);
      mef_pkg::REG_TRIGGER_ID:   prdata = 32'(cfg.trigger_id);
      mef_pkg::REG_SETTLE:       prdata = 32'(cfg.settle_frames);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/mef_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mef_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  mef_pkg::cfg_t                   cfg,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       bus,
  input  wire logic [mef_pkg::ID_W-1:0]   frame_id,
  input  wire logic [mef_pkg::PAY_W-1:0]  payload,
  output logic                            cmd_valid,
  input  wire logic                       cmd_pop,
  output mef_pkg::cmd_t                   cmd
);

  logic [mef_pkg::ID_W:0]     diff;
  logic                       hit;
  logic [mef_pkg::SLOT_W-1:0] slot;
  logic                       accept;
  logic                       store;
  mef_pkg::cmd_t              fresh;

  mef_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;

  assign diff = {1'b0, frame_id} - {1'b0, cfg.chassis_base_id};

  // Chassis wins over yaw, then pitch, then trigger.
  always_comb begin
    hit = 1'b1;
    priority if (!diff[mef_pkg::ID_W] && diff[mef_pkg::ID_W-1:2] == '0) begin
      slot = {1'b0, diff[1:0]};
    end else if (frame_id == cfg.yaw_id) begin
      slot = mef_pkg::SLOT_YAW;
    end else if (frame_id == cfg.pitch_id) begin
      slot = mef_pkg::SLOT_PITCH;
    end else if (frame_id == cfg.trigger_id) begin
      slot = mef_pkg::SLOT_TRIGGER;
    end else begin
      slot = '0;
      hit = 1'b0;
    end
  end

  assign fresh.slot = slot;
  assign fresh.position = payload[47:32];
  assign fresh.motor_speed = payload[31:16];
  assign fresh.drive_current = payload[15:0];

  assign full = (count == 2'd2);
  assign accept = push && !full;
  // Drop second-bus frames and identifiers that map to no slot.
  assign store = accept && !bus && hit && ({1'b0, slot} < mef_pkg::SLOT_LIMIT);

  assign cmd_valid = (count != 2'd0);
  assign cmd = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (store && !(cmd_pop && cmd_valid)) begin
      count_next = count + 2'd1;
    end else if (!store && cmd_pop && cmd_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (store) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      entry[wr_ptr] <= fresh;
    end
  end

endmodule

`default_nettype wire

### rtl/mef_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mef_back (
  input  wire logic   clk,
  input  wire logic   rst,
  input  mef_pkg::cfg_t cfg,
  input  wire logic   cmd_valid,
  output logic        cmd_pop,
  input  mef_pkg::cmd_t cmd,
  output logic        empty,
  input  wire logic   pop,
  output mef_pkg::res_t res
);

  logic [mef_pkg::POS_W-1:0]    last_position [mef_pkg::MOTOR_SLOTS];
  logic [mef_pkg::POS_W-1:0]    zero_offset [mef_pkg::MOTOR_SLOTS];
  logic [mef_pkg::CNT_W-1:0]    turns [mef_pkg::MOTOR_SLOTS];
  logic [mef_pkg::CNT_W-1:0]    turn_base [mef_pkg::MOTOR_SLOTS];
  logic [mef_pkg::FRAMES_W-1:0] frames_seen [mef_pkg::MOTOR_SLOTS];

  logic [mef_pkg::SLOT_W-1:0]        s;
  logic                              cal_slot;
  logic                              calib;
  logic signed [mef_pkg::WIDE_W-1:0] delta;
  logic signed [mef_pkg::WIDE_W-1:0] step;
  logic [mef_pkg::CNT_W-1:0]         turns_next;
  logic [mef_pkg::CNT_W-1:0]         base_next;
  logic [mef_pkg::CNT_W-1:0]         total;
  mef_pkg::res_t                     fresh;

  mef_pkg::res_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          take;
  logic          go;

  assign s = cmd.slot;
  assign cal_slot = (s != mef_pkg::SLOT_YAW) && (s != mef_pkg::SLOT_PITCH);
  assign calib = cal_slot && (frames_seen[s] <= {1'b0, cfg.settle_frames});

  assign delta = $signed({2'b00, cmd.position}) - $signed({2'b00, last_position[s]});

  // Unwrap: a jump past half a turn crosses the index mark.
  always_comb begin
    turns_next = turns[s];
    base_next = turn_base[s];
    step = delta;
    if (delta > mef_pkg::HALF_TURN_W) begin
      turns_next = turns[s] - 32'd1;
      base_next = turn_base[s] - mef_pkg::TURN_COUNTS;
      step = delta - mef_pkg::TURN_W;
    end else if (delta < -mef_pkg::HALF_TURN_W) begin
      turns_next = turns[s] + 32'd1;
      base_next = turn_base[s] + mef_pkg::TURN_COUNTS;
      step = delta + mef_pkg::TURN_W;
    end
  end

  assign total = base_next + 32'(cmd.position) - 32'(zero_offset[s]);

  always_comb begin
    fresh = '0;
    fresh.motor_slot = s;
    fresh.calibrating = calib;
    if (!calib) begin
      fresh.position = cmd.position;
      fresh.step_delta = step[mef_pkg::STEP_W-1:0];
      fresh.turn_count = turns_next;
      fresh.total_count = total;
      fresh.motor_speed = cmd.motor_speed;
      fresh.drive_current = cmd.drive_current;
    end
  end

  assign empty = (count == 2'd0);
  assign take = pop && !empty;
  assign go = cmd_valid && ((count != 2'd2) || take);
  assign cmd_pop = go;
  assign res = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mef_pkg::MOTOR_SLOTS; i++) begin
        last_position[i] <= '0;
        zero_offset[i] <= '0;
        turns[i] <= '0;
        turn_base[i] <= '0;
        frames_seen[i] <= '0;
      end
    end else if (go) begin
      last_position[s] <= cmd.position;
      if (cal_slot && frames_seen[s] != mef_pkg::FRAMES_MAX) begin
        frames_seen[s] <= frames_seen[s] + 9'd1;
      end
      if (calib) begin
        zero_offset[s] <= cmd.position;
      end else begin
        turns[s] <= turns_next;
        turn_base[s] <= base_next;
      end
    end
  end

  always_comb begin
    count_next = count;
    if (go && !take) begin
      count_next = count + 2'd1;
    end else if (!go && take) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (go) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      entry[wr_ptr] <= fresh;
    end
  end

endmodule

`default_nettype wire

### rtl/motor_encoder_feedback_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake               Payload
// ---------  ----------------------  ------------------------------------------------
// config     psel/penable/pwrite     paddr, pwdata, prdata; pready tied high
// request    push in, full out       bus, frame_id, payload
// result     empty out, pop in       motor_slot, calibrating, position, step_delta,
//                                    turn_count, total_count, motor_speed, drive_current
//
// One request per cycle sustained while results are popped. The front classifies a
// frame in the cycle it is taken and parks it in a two-entry queue; the back does the
// slot read-modify-write as it takes a command and writes a two-entry result queue,
// so a result reaches the ports through the command queue register and then the
// result queue register. Stalls on pop fill the result queue, then hold the command
// queue, then raise full. Reset is synchronous and clears the queues, the per-slot
// state and the registers to their defaults; no clearing pass.
// Frames on the second bus or with no matching identifier are taken and dropped.

module motor_encoder_feedback_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mef_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [mef_pkg::DATA_W-1:0]        pwdata,
  output logic      [mef_pkg::DATA_W-1:0]        prdata,
  output logic                                   pready,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              bus,
  input  wire logic [mef_pkg::ID_W-1:0]          frame_id,
  input  wire logic [mef_pkg::PAY_W-1:0]         payload,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic      [mef_pkg::SLOT_W-1:0]        motor_slot,
  output logic                                   calibrating,
  output logic      [mef_pkg::POS_W-1:0]         position,
  output logic signed [mef_pkg::STEP_W-1:0]      step_delta,
  output logic signed [mef_pkg::CNT_W-1:0]       turn_count,
  output logic signed [mef_pkg::CNT_W-1:0]       total_count,
  output logic signed [15:0]                     motor_speed,
  output logic signed [15:0]                     drive_current
);

  mef_pkg::cfg_t cfg;
  mef_pkg::cmd_t cmd;
  mef_pkg::res_t res;
  logic          cmd_valid;
  logic          cmd_pop;

  // Register file: identifiers and settle length.
  mef_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: take the request, map identifier to slot, queue the command.
  mef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .bus       (bus),
    .frame_id  (frame_id),
    .payload   (payload),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Back: per-slot calibration and turn unwrap, then the result queue.
  mef_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign motor_slot = res.motor_slot;
  assign calibrating = res.calibrating;
  assign position = res.position;
  assign step_delta = res.step_delta;
  assign turn_count = res.turn_count;
  assign total_count = res.total_count;
  assign motor_speed = res.motor_speed;
  assign drive_current = res.drive_current;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mef_pkg::*;

  // Four chassis motors sit on consecutive identifiers starting at the base.
  localparam int CHASSIS_SLOTS = 4;
  localparam int BASE_MAX = (1 << ID_W) - CHASSIS_SLOTS;
  localparam int HALF_TURN = COUNTS_PER_TURN / 2;
  localparam int NUM_REGS = 5;

  // Cycles with no handshake on any port before the run is called hung.
  localparam int STALL_LIMIT = 1000;
  // A frame that gives no result may still be in flight when the last result
  // shows up; let the pipeline run dry before touching the registers.
  localparam int QUIET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int TRAFFIC_PER_SETTING = 42;
  // Enough frames on the trigger to carry it through the default settle window.
  localparam int TRIGGER_FRAMES = 80;
  localparam int SCRIPT_LEN = 23;

  localparam cfg_t RESET_REGS = '{chassis_base_id: 11'd513, yaw_id: 11'd517,
                                  pitch_id: 11'd518, trigger_id: 11'd519,
                                  settle_frames: 8'd50};
  localparam logic [ID_W-1:0] DEF_BASE = RESET_REGS.chassis_base_id;
  localparam logic [ID_W-1:0] DEF_YAW = RESET_REGS.yaw_id;
  localparam logic [ID_W-1:0] DEF_PITCH = RESET_REGS.pitch_id;
  localparam logic [ID_W-1:0] DEF_TRIGGER = RESET_REGS.trigger_id;
  localparam res_t NO_RESULT = '0;

  localparam logic [2:0] REG_LIST [NUM_REGS] = '{REG_CHASSIS_BASE, REG_YAW_ID, REG_PITCH_ID,
                                                 REG_TRIGGER_ID, REG_SETTLE};

  // Corner settings: lowest and highest base, identifiers at both ends of the
  // range, settle window at zero and at its maximum, and these overlap orders
  // (chassis over yaw and pitch; yaw over pitch and trigger; pitch over
  // trigger).
  localparam cfg_t CORNER_SETTINGS [4] = '{
    '{chassis_base_id: 11'd0, yaw_id: 11'd2047, pitch_id: 11'd0,
      trigger_id: 11'd2047, settle_frames: 8'd0},
    '{chassis_base_id: 11'd2044, yaw_id: 11'd2046, pitch_id: 11'd2047,
      trigger_id: 11'd100, settle_frames: 8'd255},
    '{chassis_base_id: 11'd700, yaw_id: 11'd704, pitch_id: 11'd704,
      trigger_id: 11'd704, settle_frames: 8'd3},
    '{chassis_base_id: 11'd700, yaw_id: 11'd710, pitch_id: 11'd720,
      trigger_id: 11'd720, settle_frames: 8'd2}
  };

  // How a scripted frame is checked: against the predictor, against a result
  // written out by hand, or as a frame that must be dropped.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_RESULT, ROW_DROP} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic                    second_bus;
    logic [ID_W-1:0]         id;
    logic [PAY_W-1:0]        pay;
    res_t                    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic push = 1'b0;
  logic full;
  logic bus = 1'b0;
  logic [ID_W-1:0] frame_id = '0;
  logic [PAY_W-1:0] payload = '0;

  logic empty;
  logic pop = 1'b0;
  logic [SLOT_W-1:0] motor_slot;
  logic calibrating;
  logic [POS_W-1:0] position;
  logic signed [STEP_W-1:0] step_delta;
  logic signed [CNT_W-1:0] turn_count;
  logic signed [CNT_W-1:0] total_count;
  logic signed [15:0] motor_speed;
  logic signed [15:0] drive_current;

  // Shadow of the block: register copy and per-slot tracking state.
  cfg_t regs_model;
  logic [POS_W-1:0] last_pos [MOTOR_SLOTS];
  logic [POS_W-1:0] zero_pos [MOTOR_SLOTS];
  logic [CNT_W-1:0] turns [MOTOR_SLOTS];
  logic [FRAMES_W-1:0] frames_seen [MOTOR_SLOTS];

  // Feedback results still owed by the block, oldest first.
  res_t pending_feedback [$];

  int mismatches = 0;
  int frames_taken = 0;
  int results_checked = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int pop_wait = 0;
  bit push_lazy;
  bit pop_lazy;

  // Directed frames, run with the reset settings. Hand-written results cover
  // calibration after reset, both buses, unmatched identifiers and the unwrap
  // edges: a step of exactly half a turn, one count past it, and the largest
  // jumps the 16-bit position allows.
  row_t script [SCRIPT_LEN] = '{
    '{ROW_RESULT, 1'b0, DEF_BASE, {16'hFFFF, 16'h7FFF, 16'h8000},
      '{3'd0, 1'b1, 16'd0, 17'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0}},
    '{ROW_RESULT, 1'b0, DEF_BASE + 11'd3, 48'h0,
      '{3'd3, 1'b1, 16'd0, 17'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0}},
    '{ROW_DROP, 1'b0, DEF_BASE - 11'd1, 48'h1234_5678_9ABC, NO_RESULT},
    '{ROW_DROP, 1'b0, DEF_TRIGGER + 11'd1, 48'h0FED_CBA9_8765, NO_RESULT},
    '{ROW_DROP, 1'b1, DEF_BASE, 48'hFFFF_FFFF_FFFF, NO_RESULT},
    '{ROW_DROP, 1'b1, DEF_YAW, 48'h1000_0000_0000, NO_RESULT},
    '{ROW_RESULT, 1'b0, DEF_YAW, {16'h1000, 16'h8000, 16'h7FFF},
      '{SLOT_YAW, 1'b0, 16'h1000, 17'sd4096, 32'sd0, 32'sd4096, 16'h8000, 16'h7FFF}},
    '{ROW_RESULT, 1'b0, DEF_YAW, 48'h0,
      '{SLOT_YAW, 1'b0, 16'h0000, -17'sd4096, 32'sd0, 32'sd0, 16'h0000, 16'h0000}},
    '{ROW_RESULT, 1'b0, DEF_YAW, {16'h1001, 16'h0001, 16'hFFFF},
      '{SLOT_YAW, 1'b0, 16'h1001, -17'sd4095, -32'sd1, -32'sd4095, 16'h0001, 16'hFFFF}},
    '{ROW_RESULT, 1'b0, DEF_YAW, 48'h0,
      '{SLOT_YAW, 1'b0, 16'h0000, 17'sd4095, 32'sd0, 32'sd0, 16'h0000, 16'h0000}},
    '{ROW_RESULT, 1'b0, DEF_YAW, {16'hFFFF, 16'hFFFF, 16'h0000},
      '{SLOT_YAW, 1'b0, 16'hFFFF, 17'sd57343, -32'sd1, 32'sd57343, 16'hFFFF, 16'h0000}},
    '{ROW_RESULT, 1'b0, DEF_YAW, 48'h0,
      '{SLOT_YAW, 1'b0, 16'h0000, -17'sd57343, 32'sd0, 32'sd0, 16'h0000, 16'h0000}},
    '{ROW_RESULT, 1'b0, DEF_PITCH, {16'h1FFF, 16'h7FFF, 16'h7FFF},
      '{SLOT_PITCH, 1'b0, 16'h1FFF, -17'sd1, -32'sd1, -32'sd1, 16'h7FFF, 16'h7FFF}},
    '{ROW_RESULT, 1'b0, DEF_PITCH, {16'h0000, 16'h8000, 16'h8000},
      '{SLOT_PITCH, 1'b0, 16'h0000, 17'sd1, 32'sd0, 32'sd0, 16'h8000, 16'h8000}},
    '{ROW_PREDICT, 1'b0, DEF_PITCH, 48'h0064_0123_FEDC, NO_RESULT},
    '{ROW_RESULT, 1'b0, DEF_TRIGGER, {16'h04D2, 16'h1111, 16'h2222},
      '{SLOT_TRIGGER, 1'b1, 16'd0, 17'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0}},
    '{ROW_DROP, 1'b0, 11'd0, 48'hFFFF_FFFF_FFFF, NO_RESULT},
    '{ROW_DROP, 1'b0, 11'h7FF, 48'h0, NO_RESULT},
    '{ROW_PREDICT, 1'b0, DEF_BASE + 11'd1, 48'h0800_0400_0200, NO_RESULT},
    '{ROW_PREDICT, 1'b0, DEF_BASE + 11'd2, 48'hE000_C000_A000, NO_RESULT},
    '{ROW_PREDICT, 1'b0, DEF_YAW, 48'hFFFF_FFFF_FFFF, NO_RESULT},
    '{ROW_PREDICT, 1'b1, 11'h7FF, 48'hFFFF_FFFF_FFFF, NO_RESULT},
    '{ROW_PREDICT, 1'b0, DEF_PITCH, 48'h2000_5555_AAAA, NO_RESULT}
  };

  motor_encoder_feedback_tracker uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Route an identifier the way the block does: chassis first, then yaw,
  // pitch and trigger. Return -1 when nothing claims it.
  function automatic int find_slot(input logic [ID_W-1:0] id);
    if (id >= regs_model.chassis_base_id && id - regs_model.chassis_base_id < CHASSIS_SLOTS)
      return int'(id - regs_model.chassis_base_id);
    if (id == regs_model.yaw_id) return int'(SLOT_YAW);
    if (id == regs_model.pitch_id) return int'(SLOT_PITCH);
    if (id == regs_model.trigger_id) return int'(SLOT_TRIGGER);
    return -1;
  endfunction

  // Advance the shadow state by one frame and build the result it should
  // produce. Return 0 for frames that the block must drop.
  function automatic bit track_frame(input logic second_bus, input logic [ID_W-1:0] id,
                                     input logic [PAY_W-1:0] pay, output res_t r);
    int slot;
    int delta;
    int step;
    logic [POS_W-1:0] pos;
    logic [FRAMES_W-1:0] cnt;
    r = '0;
    if (second_bus) return 1'b0;
    slot = find_slot(id);
    if (slot < 0 || slot >= MOTOR_SLOTS) return 1'b0;
    pos = pay[PAY_W-1 -: POS_W];
    r.motor_slot = SLOT_W'(slot);
    // Chassis and trigger capture their zero offset while the settle window
    // is open; the frame count holds at its top value.
    if (slot < CHASSIS_SLOTS || slot == int'(SLOT_TRIGGER)) begin
      cnt = frames_seen[slot];
      if (cnt != FRAMES_MAX) frames_seen[slot] = cnt + 1'b1;
      if (cnt <= FRAMES_W'(regs_model.settle_frames)) begin
        last_pos[slot] = pos;
        zero_pos[slot] = pos;
        r.calibrating = 1'b1;
        return 1'b1;
      end
    end
    // A jump of more than half a turn means the encoder wrapped.
    delta = int'(pos) - int'(last_pos[slot]);
    if (delta > HALF_TURN) begin
      turns[slot] = turns[slot] - 1'b1;
      step = delta - COUNTS_PER_TURN;
    end else if (delta < -HALF_TURN) begin
      turns[slot] = turns[slot] + 1'b1;
      step = delta + COUNTS_PER_TURN;
    end else begin
      step = delta;
    end
    last_pos[slot] = pos;
    r.position = pos;
    r.step_delta = step[STEP_W-1:0];
    r.turn_count = turns[slot];
    r.total_count = turns[slot] * TURN_COUNTS + CNT_W'(pos) - CNT_W'(zero_pos[slot]);
    r.motor_speed = pay[31:16];
    r.drive_current = pay[15:0];
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] reg_field(input cfg_t c, input logic [2:0] idx);
    case (idx)
      REG_CHASSIS_BASE: return DATA_W'(c.chassis_base_id);
      REG_YAW_ID: return DATA_W'(c.yaw_id);
      REG_PITCH_ID: return DATA_W'(c.pitch_id);
      REG_TRIGGER_ID: return DATA_W'(c.trigger_id);
      REG_SETTLE: return DATA_W'(c.settle_frames);
      default: return '0;
    endcase
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // One register transfer: setup cycle, then access until pready. Writes
  // update the shadow copy; reads compare against the given value.
  task automatic reg_access(input bit wr, input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wr ? value : '0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      case (idx)
        REG_CHASSIS_BASE: regs_model.chassis_base_id = value[ID_W-1:0];
        REG_YAW_ID: regs_model.yaw_id = value[ID_W-1:0];
        REG_PITCH_ID: regs_model.pitch_id = value[ID_W-1:0];
        REG_TRIGGER_ID: regs_model.trigger_id = value[ID_W-1:0];
        REG_SETTLE: regs_model.settle_frames = value[SETTLE_W-1:0];
        default: ;
      endcase
    end else if (prdata !== value) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, prdata);
      mismatches++;
    end
  endtask

  task automatic check_regs();
    foreach (REG_LIST[i]) reg_access(1'b0, REG_LIST[i], reg_field(regs_model, REG_LIST[i]));
  endtask

  task automatic program_regs(input cfg_t c);
    foreach (REG_LIST[i]) reg_access(1'b1, REG_LIST[i], reg_field(c, REG_LIST[i]));
    check_regs();
    settings_used++;
  endtask

  // Drop the request line and wait until every owed result is in, then let
  // any dropped frames drain out of the front end.
  task automatic wait_quiet();
    push <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Offer one frame, hold it until the block takes it, then record what it
  // owes. Request stays high on return so back-to-back frames need no gap.
  task automatic send_frame(input logic second_bus, input logic [ID_W-1:0] id,
                            input logic [PAY_W-1:0] pay, input row_kind_e kind,
                            input res_t want);
    int gap;
    bit hit;
    res_t predicted;
    if ($urandom_range(0, 31) == 0) push_lazy = !push_lazy;
    gap = push_lazy ? int'($urandom_range(0, 14)) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    bus <= second_bus;
    frame_id <= id;
    payload <= pay;
    do @(posedge clk); while (full);
    frames_taken++;
    hit = track_frame(second_bus, id, pay, predicted);
    if (kind == ROW_RESULT) pending_feedback.push_back(want);
    else if (kind == ROW_PREDICT && hit) pending_feedback.push_back(predicted);
  endtask

  // Send a well-formed frame to one configured motor. The new position sits
  // near the last one most of the time, wraps across the turn boundary as a
  // real encoder does, and sometimes lands near half a turn away or anywhere.
  task automatic send_tracked(input int target);
    logic [ID_W-1:0] id;
    logic [POS_W-1:0] prev;
    logic [POS_W-1:0] pos;
    int slot;
    int step;
    int mode;
    if (target < CHASSIS_SLOTS) id = regs_model.chassis_base_id + ID_W'(target);
    else if (target == int'(SLOT_YAW)) id = regs_model.yaw_id;
    else if (target == int'(SLOT_PITCH)) id = regs_model.pitch_id;
    else id = regs_model.trigger_id;
    slot = find_slot(id);
    prev = (slot >= 0 && slot < MOTOR_SLOTS) ? last_pos[slot] : '0;
    mode = $urandom_range(0, 9);
    if (mode < 6) step = int'($urandom_range(0, 400)) - 200;
    else if (mode < 8) step = ($urandom_range(0, 1) ? HALF_TURN : -HALF_TURN)
                              + int'($urandom_range(0, 12)) - 6;
    else step = int'($urandom_range(0, 2 * COUNTS_PER_TURN - 1)) - COUNTS_PER_TURN;
    if (mode == 9) pos = POS_W'($urandom);
    else pos = POS_W'((int'(prev) + step) & (COUNTS_PER_TURN - 1));
    send_frame(1'b0, id, {pos, 16'($urandom), 16'($urandom)}, ROW_PREDICT, NO_RESULT);
  endtask

  // Mostly tracked motor traffic; the rest is noise on any bus and identifier.
  task automatic run_traffic(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 80)
        send_tracked($urandom_range(0, MOTOR_SLOTS - 1));
      else
        send_frame(1'($urandom), ID_W'($urandom), PAY_W'({$urandom, $urandom}),
                   ROW_PREDICT, NO_RESULT);
    end
  endtask

  // Result side: take the oldest result whenever pop and not empty, compare
  // it field by field, then draw how long to stall before the next one.
  always @(posedge clk) begin
    res_t want;
    int hold;
    if (rst) begin
      pop <= 1'b0;
      pop_wait <= 0;
    end else if (pop && !empty) begin
      if (pending_feedback.size() == 0) begin
        $error("result for slot %0d arrived with nothing pending", motor_slot);
        mismatches++;
      end else begin
        want = pending_feedback.pop_front();
        check_field("motor_slot", want.motor_slot, motor_slot);
        check_field("calibrating", want.calibrating, calibrating);
        check_field("position", want.position, position);
        check_field("step_delta", want.step_delta, step_delta);
        check_field("turn_count", want.turn_count, turn_count);
        check_field("total_count", want.total_count, total_count);
        check_field("motor_speed", want.motor_speed, motor_speed);
        check_field("drive_current", want.drive_current, drive_current);
      end
      results_checked++;
      if ($urandom_range(0, 31) == 0) pop_lazy = !pop_lazy;
      hold = pop_lazy ? int'($urandom_range(0, 14)) : 0;
      pop <= (hold == 0);
      pop_wait <= hold;
    end else if (!pop) begin
      if (pop_wait <= 1) pop <= 1'b1;
      else pop_wait <= pop_wait - 1;
    end
  end

  // Watchdog: any handshake on any port restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("hung: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_feedback.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t c;
    regs_model = RESET_REGS;
    foreach (last_pos[i]) begin
      last_pos[i] = '0;
      zero_pos[i] = '0;
      turns[i] = '0;
      frames_seen[i] = '0;
    end
    push_lazy = 1'($urandom);
    pop_lazy = 1'($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Registers must come out of reset at their defaults.
    check_regs();

    foreach (script[i])
      send_frame(script[i].second_bus, script[i].id, script[i].pay, script[i].kind,
                 script[i].want);

    // Corner settings, then a few random ones that tend to overlap the
    // identifiers and keep the settle window short.
    foreach (CORNER_SETTINGS[i]) begin
      wait_quiet();
      program_regs(CORNER_SETTINGS[i]);
      run_traffic(TRAFFIC_PER_SETTING);
    end
    repeat (3) begin
      c.chassis_base_id = ID_W'($urandom_range(0, BASE_MAX));
      c.yaw_id = $urandom_range(0, 1) ? c.chassis_base_id + ID_W'($urandom_range(0, 7))
                                      : ID_W'($urandom);
      c.pitch_id = $urandom_range(0, 1) ? c.chassis_base_id + ID_W'($urandom_range(0, 7))
                                        : ID_W'($urandom);
      c.trigger_id = $urandom_range(0, 1) ? c.chassis_base_id + ID_W'($urandom_range(0, 7))
                                          : ID_W'($urandom);
      c.settle_frames = ($urandom_range(0, 3) == 0) ? SETTLE_W'($urandom)
                                                    : SETTLE_W'($urandom_range(0, 6));
      wait_quiet();
      program_regs(c);
      run_traffic(TRAFFIC_PER_SETTING);
    end

    // Back to the reset settings; run the trigger through its settle window,
    // then mix in ordinary traffic.
    wait_quiet();
    program_regs(RESET_REGS);
    repeat (TRIGGER_FRAMES) send_tracked(int'(SLOT_TRIGGER));
    run_traffic(TRAFFIC_PER_SETTING);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Took %0d feedback frames and checked %0d results over %0d register settings,",
             frames_taken, results_checked, settings_used);
    $display("with unwrap edges, identifier overlaps and the end of the settle window.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
